// ----- hdl/cbam_pkg.sv -----
// shared types and codes for the contiguous block allocation map
package cbam_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int OWNER_BITS_DEF = 8;

  localparam logic [8:0] BLOCKS_IN_USE_RST = 9'd256;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] owner_id;
    logic [7:0] first_blk;
    logic [8:0] block_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       entry_used;
    logic [7:0] entry_owner;
  } out_item_t;

endpackage

// ----- hdl/contiguous_block_allocation_map_unit.sv -----
// contiguous block allocation map: owner table with allocate, free and read commands
//
// Usage: drive in_data and raise start while busy is low; the command is taken at
// that edge and busy stays high until it is done. Exactly one result beat follows
// each command on out_data, marked by out_valid for one cycle; the receiver cannot
// hold it off. cfg_data (blocks_in_use) is written when cfg_valid and cfg_ready
// are high; cfg_ready is always high, and writes belong between commands.
// Steps of each command, from the accepting edge to the result beat:
//   allocate out of range or empty, read out of range, unknown mode: result beat only
//   allocate: check scan, fill, result beat; a conflict ends it early
//   free: scan of the whole table through the read pipeline, result beat
//   read: registered table read, result beat
// busy is low during the result beat, so the next command can be taken at the edge
// that takes the result.
// The owner table is a single-port-write / single-port-read memory with a
// registered read.
// After reset the table is cleared one entry a cycle with busy high, and
// blocks_in_use returns to 256.
module contiguous_block_allocation_map_unit #(
  parameter int TABLE_DEPTH = cbam_pkg::TABLE_DEPTH_DEF,
  parameter int OWNER_BITS = cbam_pkg::OWNER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cbam_pkg::in_item_t  in_data,
  output logic                out_valid,
  output cbam_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [8:0]          cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_RDOUT = 3'd6;

  logic [OWNER_BITS:0]   mem [TABLE_DEPTH];
  logic [OWNER_BITS:0]   rd_q;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         end_r, end_nxt;
  logic [CW-1:0]         base_r, base_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         lag_r, lag_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cbam_pkg::out_item_t   out_data_r, out_data_nxt;
  logic [8:0]            cfg_r;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [OWNER_BITS:0]   wr_data;
  logic [8:0]            limit;
  logic [9:0]            sum;
  logic                  rd_used;
  logic [OWNER_BITS-1:0] rd_owner;

  assign limit    = (32'(cfg_r) < TABLE_DEPTH) ? cfg_r : 9'(TABLE_DEPTH);
  assign sum      = {2'b00, in_data.first_blk} + {1'b0, in_data.block_count};
  assign rd_used  = rd_q[OWNER_BITS];
  assign rd_owner = rd_q[OWNER_BITS-1:0];

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // owner table, read every cycle at the scan pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[cnt_r[AW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    base_nxt      = base_r;
    pend_nxt      = 1'b0;
    lag_nxt       = cnt_r[AW-1:0];
    owner_nxt     = owner_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = '0;
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (cnt_r == CW'(TABLE_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = CW'(cnt_r + 1'b1);
        end
      end
      S_IDLE: begin
        if (start) begin
          owner_nxt = OWNER_BITS'(in_data.owner_id);
          out_data_nxt = '{status: cbam_pkg::ST_OK, entry_used: 1'b0, entry_owner: 8'd0};
          case (in_data.mode)
            cbam_pkg::MODE_ALLOC: begin
              if (sum > {1'b0, limit}) begin
                out_data_nxt.status = cbam_pkg::ST_RANGE;
                out_valid_nxt       = 1'b1;
              end else if (in_data.block_count == 9'd0) begin
                out_valid_nxt = 1'b1;
              end else begin
                cnt_nxt   = CW'(in_data.first_blk);
                base_nxt  = CW'(in_data.first_blk);
                end_nxt   = CW'(sum);
                state_nxt = S_CHECK;
              end
            end
            cbam_pkg::MODE_FREE: begin
              cnt_nxt   = '0;
              end_nxt   = CW'(TABLE_DEPTH);
              state_nxt = S_FREE;
            end
            cbam_pkg::MODE_READ: begin
              if ({1'b0, in_data.first_blk} >= limit) begin
                out_data_nxt.status = cbam_pkg::ST_RANGE;
                out_valid_nxt       = 1'b1;
              end else begin
                cnt_nxt   = CW'(in_data.first_blk);
                state_nxt = S_READ;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CHECK: begin
        // rd_q holds the entry addressed in the previous cycle when pend_r is set
        if (pend_r && rd_used) begin
          out_data_nxt.status = cbam_pkg::ST_CONFLICT;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else if (cnt_r != end_r) begin
          pend_nxt = 1'b1;
          cnt_nxt  = CW'(cnt_r + 1'b1);
        end else if (!pend_r) begin
          cnt_nxt   = base_r;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, owner_r};
        if (CW'(cnt_r + 1'b1) == end_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt = CW'(cnt_r + 1'b1);
        end
      end
      S_FREE: begin
        if (pend_r && rd_used && (rd_owner == owner_r)) begin
          wr_en   = 1'b1;
          wr_addr = lag_r;
        end
        if (cnt_r != end_r) begin
          pend_nxt = 1'b1;
          cnt_nxt  = CW'(cnt_r + 1'b1);
        end else if (!pend_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        out_data_nxt.entry_used  = rd_used;
        out_data_nxt.entry_owner = rd_used ? 8'(rd_owner) : 8'd0;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= cbam_pkg::BLOCKS_IN_USE_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    base_r     <= base_nxt;
    lag_r      <= lag_nxt;
    owner_r    <= owner_nxt;
    out_data_r <= out_data_nxt;
  end

  a_out_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result beat without a command in flight");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while a command is still running");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !wr_en)
    else $error("table write while idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("scan pointer past the table");

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the block allocation map: directed table, then random phases
`timescale 1ns / 100ps

module tb;

  localparam int MAP_DEPTH = cbam_pkg::TABLE_DEPTH_DEF;
  localparam int PHASE_ITEMS = 192;
  localparam int DRAIN_CYCLES = 600;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    cbam_pkg::in_item_t  cmd;
    bit                  typed;
    cbam_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  cbam_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  cbam_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [8:0]          cfg_data = '0;

  // shadow of the owner table and the limit register
  bit         blk_used [MAP_DEPTH];
  logic [7:0] blk_owner [MAP_DEPTH];
  logic [8:0] limit_reg = cbam_pkg::BLOCKS_IN_USE_RST;

  cbam_pkg::out_item_t pending_responses [$];
  dir_row_t            directed_rows [$];
  int                  errors = 0;
  int                  limit_plan [6] = '{200, 0, 511, 1, 37, 256};

  contiguous_block_allocation_map_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int active_limit();
    return (limit_reg < MAP_DEPTH) ? int'(limit_reg) : MAP_DEPTH;
  endfunction

  // applies one command to the shadow table and returns its response
  function automatic cbam_pkg::out_item_t table_response(input cbam_pkg::in_item_t c);
    cbam_pkg::out_item_t r;
    int                  lim;
    int                  first;
    int                  cnt;
    bit                  clash;
    r = '0;
    lim = active_limit();
    first = int'(c.first_blk);
    cnt = int'(c.block_count);
    case (c.mode)
      cbam_pkg::MODE_ALLOC: begin
        if (first + cnt > lim) begin
          r.status = cbam_pkg::ST_RANGE;
        end else begin
          clash = 1'b0;
          for (int i = first; i < first + cnt; i++)
            if (blk_used[i]) clash = 1'b1;
          if (clash) begin
            r.status = cbam_pkg::ST_CONFLICT;
          end else begin
            for (int i = first; i < first + cnt; i++) begin
              blk_used[i] = 1'b1;
              blk_owner[i] = c.owner_id;
            end
            r.status = cbam_pkg::ST_OK;
          end
        end
      end
      cbam_pkg::MODE_FREE: begin
        // whole built table, even above a lowered limit
        for (int i = 0; i < MAP_DEPTH; i++) begin
          if (blk_used[i] && blk_owner[i] == c.owner_id) begin
            blk_used[i] = 1'b0;
            blk_owner[i] = '0;
          end
        end
        r.status = cbam_pkg::ST_OK;
      end
      cbam_pkg::MODE_READ: begin
        if (first >= lim) begin
          r.status = cbam_pkg::ST_RANGE;
        end else begin
          r.status = cbam_pkg::ST_OK;
          r.entry_used = blk_used[first];
          r.entry_owner = blk_used[first] ? blk_owner[first] : 8'd0;
        end
      end
      default: r.status = cbam_pkg::ST_OK;
    endcase
    return r;
  endfunction

  function automatic cbam_pkg::in_item_t random_command();
    cbam_pkg::in_item_t c;
    int                 lim;
    int                 room;
    int                 pick;
    lim = active_limit();
    pick = $urandom_range(0, 99);
    if (pick < 45) c.mode = cbam_pkg::MODE_ALLOC;
    else if (pick < 58) c.mode = cbam_pkg::MODE_FREE;
    else if (pick < 95) c.mode = cbam_pkg::MODE_READ;
    else c.mode = MODE_NONE;
    // small owner pool so frees keep finding blocks to release
    if ($urandom_range(0, 99) < 85) c.owner_id = 8'($urandom_range(0, 7));
    else c.owner_id = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 80 && lim > 0) c.first_blk = 8'($urandom_range(0, lim - 1));
    else c.first_blk = 8'($urandom_range(0, 255));
    room = lim - int'(c.first_blk);
    pick = $urandom_range(0, 99);
    if (pick < 55) c.block_count = 9'($urandom_range(1, 8));
    else if (pick < 70) c.block_count = 9'($urandom_range(0, 40));
    else if (pick < 78) c.block_count = '0;
    else if (pick < 90) c.block_count = 9'((room > 0) ? room : 1);
    else c.block_count = 9'($urandom_range(0, 511));
    return c;
  endfunction

  task automatic add_row(input logic [1:0] m, input logic [7:0] own, input logic [7:0] sb,
                         input logic [8:0] cnt, input bit typed, input logic [1:0] st,
                         input logic used, input logic [7:0] eo);
    dir_row_t r;
    r.cmd.mode = m;
    r.cmd.owner_id = own;
    r.cmd.first_blk = sb;
    r.cmd.block_count = cnt;
    r.typed = typed;
    r.want.status = st;
    r.want.entry_used = used;
    r.want.entry_owner = eo;
    directed_rows.push_back(r);
  endtask

  // leaves start high so back-to-back commands need no extra assignment
  task automatic issue(input cbam_pkg::in_item_t cmd, input bit typed,
                       input cbam_pkg::out_item_t want);
    cbam_pkg::out_item_t resp;
    start <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    resp = table_response(cmd);
    pending_responses.push_back(typed ? want : resp);
  endtask

  task automatic idle_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_limit(input logic [8:0] value);
    start <= 1'b0;
    while (pending_responses.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    cbam_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_responses.size() == 0) begin
        $error("result beat with nothing expected: status=%0d used=%0d owner=%0d",
               out_data.status, out_data.entry_used, out_data.entry_owner);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.entry_used !== want.entry_used) begin
          $error("entry_used: expected %0d, got %0d", want.entry_used, out_data.entry_used);
          errors++;
        end
        if (out_data.entry_owner !== want.entry_owner) begin
          $error("entry_owner: expected %0d, got %0d", want.entry_owner, out_data.entry_owner);
          errors++;
        end
      end
    end
  end

  initial begin : run_stimulus
    int idle_pct;
    for (int i = 0; i < MAP_DEPTH; i++) begin
      blk_used[i] = 1'b0;
      blk_owner[i] = '0;
    end

    // fresh table, limit 256
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd0,   9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'hFF, 8'd255, 9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'hFF, 8'd0,   9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'h01, 8'd255, 9'd2,   1'b1, cbam_pkg::ST_RANGE,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'h01, 8'd0,   9'd511, 1'b1, cbam_pkg::ST_RANGE,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'h01, 8'd0,   9'd256, 1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd255, 9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b1, 8'h01);
    add_row(cbam_pkg::MODE_ALLOC, 8'h02, 8'd128, 9'd1,   1'b1, cbam_pkg::ST_CONFLICT,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_FREE,  8'h02, 8'd0,   9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd128, 9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b1, 8'h01);
    add_row(cbam_pkg::MODE_FREE,  8'h01, 8'd0,   9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd0,   9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'hAA, 8'h55,  9'd3,   1'b0, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'h55, 8'hAA,  9'h155, 1'b1, cbam_pkg::ST_RANGE,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'h00, 8'h57,  9'd4,   1'b1, cbam_pkg::ST_CONFLICT,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'h57,  9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b1, 8'hAA);
    add_row(MODE_NONE,            8'hFF, 8'hFF,  9'h1FF, 1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'h00, 8'd255, 9'd1,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd255, 9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b1, 8'h00);
    add_row(cbam_pkg::MODE_FREE,  8'h00, 8'd0,   9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd255, 9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_FREE,  8'hAA, 8'd0,   9'd0,   1'b1, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_ALLOC, 8'h07, 8'd10,  9'd20,  1'b0, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd29,  9'd0,   1'b0, cbam_pkg::ST_OK,
            1'b0, 8'h00);
    add_row(cbam_pkg::MODE_READ,  8'h00, 8'd30,  9'd0,   1'b0, cbam_pkg::ST_OK,
            1'b0, 8'h00);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    // sender idles 20 percent, then 68 percent, then not at all
    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 20 : (phase < 4) ? 68 : 0;
      write_limit(9'(limit_plan[phase]));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        idle_gap(idle_pct);
        issue(random_command(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_responses.size() == 0) begin
      $display("** contiguous_block_allocation_map_unit: PASSED **");
    end else begin
      $display("** contiguous_block_allocation_map_unit: FAILED **");
    end
    $finish;
  end

  initial begin : run_limit
    #25000000;
    $display("** contiguous_block_allocation_map_unit: FAILED **");
    $finish;
  end

endmodule
